// ----- hdl/qalu_pkg.sv -----
package qalu_pkg;

  // Port width and internal fixed-point format
  localparam int PORT_W = 32;
  localparam int CW     = 32;
  localparam int FB     = 16;

  // Derived widths
  localparam int PW  = 2 * CW;        // one signed product
  localparam int SW  = PW + 2;        // signed sum of four products
  localparam int MW  = SW - 1;        // magnitude of that sum
  localparam int NW  = MW + FB;       // scaled dividend magnitude
  localparam int DW  = PW + 1;        // squared norm, unsigned
  localparam int QW  = CW + 1;        // quotient with overflow bit on top
  localparam int RW  = ((NW > DW + CW) ? NW : DW + CW) + 1;
  localparam int LW  = RW + 2;        // signed width ahead of saturation

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Operand component selected for each result component and term
  localparam logic [1:0] BSEL [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // Term is subtracted in the Hamilton product
  localparam logic BNEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    op_e                 op;
    logic [3:0][CW-1:0]  early;      // final result for add, sub and mul
    logic                early_sat;
    logic                dz;
    logic [3:0]          neg;        // dividend sign per component
  } ctl_t;

  typedef struct packed {
    ctl_t                ctl;
    logic [3:0][MW-1:0]  mag;
    logic [DW-1:0]       den;
  } front_t;

  typedef struct packed {
    ctl_t                ctl;
    logic [3:0][QW-1:0]  quo;
  } quo_t;

  // Clamp to the CW-bit signed range: {clamped flag, value}
  function automatic logic [CW:0] sat_f(input logic signed [LW-1:0] v);
    logic signed [LW-1:0] maxv;
    logic signed [LW-1:0] minv;
    logic [CW:0]          r;
    maxv = {{(LW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    minv = ~maxv;
    if (v > maxv) begin
      r = {1'b1, maxv[CW-1:0]};
    end else if (v < minv) begin
      r = {1'b1, minv[CW-1:0]};
    end else begin
      r = {1'b0, v[CW-1:0]};
    end
    return r;
  endfunction

endpackage

// ----- hdl/qalu_front.sv -----
module qalu_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  qalu_pkg::op_e                    op_i,
  input  logic [3:0][qalu_pkg::CW-1:0]     a_i,
  input  logic [3:0][qalu_pkg::CW-1:0]     b_i,
  output logic                             valid_o,
  output qalu_pkg::front_t                 data_o
);
  import qalu_pkg::*;

  logic [3:0] v_q;

  // operand capture
  op_e                    op0_q;
  logic signed [CW-1:0]   a0_q [4];
  logic signed [CW-1:0]   b0_q [4];

  // products and add/sub result
  op_e                    op1_q;
  logic signed [PW-1:0]   prod1_d [4][4];
  logic signed [PW-1:0]   prod1_q [4][4];
  logic [PW-1:0]          sq1_d [4];
  logic [PW-1:0]          sq1_q [4];
  logic [3:0][CW-1:0]     as1_d, as1_q;
  logic                   as_sat1_d, as_sat1_q;

  // sums of products
  op_e                    op2_q;
  logic signed [SW-1:0]   sum2_d [4];
  logic signed [SW-1:0]   sum2_q [4];
  logic [DW-1:0]          den2_d, den2_q;
  logic [3:0][CW-1:0]     as2_q;
  logic                   as_sat2_q;

  // setup for the divider
  front_t                 out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op0_q <= op_i;
      for (int c = 0; c < 4; c++) begin
        a0_q[c] <= a_i[c];
        b0_q[c] <= b_i[c];
      end
    end
  end

  always_comb begin
    logic signed [LW-1:0] s;
    logic [CW:0]          r;
    as_sat1_d = 1'b0;
    for (int t = 0; t < 4; t++) begin
      for (int u = 0; u < 4; u++) begin
        prod1_d[t][u] = PW'(a0_q[t]) * PW'(b0_q[u]);
      end
      sq1_d[t] = $unsigned(PW'(b0_q[t]) * PW'(b0_q[t]));
    end
    for (int c = 0; c < 4; c++) begin
      if (op0_q == OP_SUB) begin
        s = LW'(a0_q[c]) - LW'(b0_q[c]);
      end else begin
        s = LW'(a0_q[c]) + LW'(b0_q[c]);
      end
      r = sat_f(s);
      as1_d[c] = r[CW-1:0];
      as_sat1_d = as_sat1_d | r[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q     <= op0_q;
      prod1_q   <= prod1_d;
      sq1_q     <= sq1_d;
      as1_q     <= as1_d;
      as_sat1_q <= as_sat1_d;
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] term;
    logic                 flip;
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        term = SW'(prod1_q[t][BSEL[c][t]]);
        // the conjugate flips every imaginary part of b
        flip = BNEG[c][t] ^ ((op1_q == OP_DIV) && (BSEL[c][t] != 2'd0));
        acc  = flip ? (acc - term) : (acc + term);
      end
      sum2_d[c] = acc;
    end
    den2_d = DW'(sq1_q[0]) + DW'(sq1_q[1]) + DW'(sq1_q[2]) + DW'(sq1_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op2_q     <= op1_q;
      sum2_q    <= sum2_d;
      den2_q    <= den2_d;
      as2_q     <= as1_q;
      as_sat2_q <= as_sat1_q;
    end
  end

  always_comb begin
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] ab;
    logic [CW:0]          r;
    logic [3:0][CW-1:0]   mv;
    logic                 msat;
    msat = 1'b0;
    for (int c = 0; c < 4; c++) begin
      sh    = sum2_q[c] >>> FB;
      r     = sat_f(LW'(sh));
      mv[c] = r[CW-1:0];
      msat  = msat | r[CW];
      out_d.ctl.neg[c] = sum2_q[c][SW-1];
      ab    = sum2_q[c][SW-1] ? -sum2_q[c] : sum2_q[c];
      out_d.mag[c] = ab[MW-1:0];
    end
    out_d.ctl.op        = op2_q;
    out_d.ctl.early     = (op2_q == OP_MUL) ? mv : as2_q;
    out_d.ctl.early_sat = (op2_q == OP_MUL) ? msat : as_sat2_q;
    out_d.ctl.dz        = (op2_q == OP_DIV) && (den2_q == '0);
    out_d.den           = den2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = out_q;

endmodule

// ----- hdl/qalu_div.sv -----
module qalu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  qalu_pkg::front_t  data_i,
  output logic              valid_o,
  output qalu_pkg::quo_t    data_o
);
  import qalu_pkg::*;

  logic [QW-1:0]          v_q;
  logic [3:0][RW-1:0]     rem_q [QW];
  logic [3:0][QW-1:0]     quo_q [QW];
  logic [DW-1:0]          den_q [QW];
  ctl_t                   ctl_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  // One quotient bit per stage, most significant first; the top bit
  // only flags a quotient too large for the result range.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [3:0][RW-1:0] rem_in, rem_d;
    logic [3:0][QW-1:0] quo_in, quo_d;
    logic [DW-1:0]      den_in;
    ctl_t               ctl_in;
    logic [RW-1:0]      dsh;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          rem_in[l] = RW'(data_i.mag[l]) << FB;
        end
      end
      assign quo_in = '0;
      assign den_in = data_i.den;
      assign ctl_in = data_i.ctl;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign dsh = RW'(den_in) << (QW - 1 - k);

    always_comb begin
      logic ge;
      for (int l = 0; l < 4; l++) begin
        ge       = rem_in[l] >= dsh;
        rem_d[l] = ge ? (rem_in[l] - dsh) : rem_in[l];
        quo_d[l] = quo_in[l];
        quo_d[l][QW-1-k] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        ctl_q[k] <= ctl_in;
      end
    end
  end

  assign valid_o     = v_q[QW-1];
  assign data_o.ctl  = ctl_q[QW-1];
  assign data_o.quo  = quo_q[QW-1];

endmodule

// ----- hdl/quaternion_alu.sv -----
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    opcode_i, a_r_i..a_k_i, b_r_i..b_k_i
// out      out_valid_o / out_ready_i  res_r_o..res_k_o, saturated_o, divide_by_zero_o
//
// Throughput is one transaction per cycle for every opcode while no result is held.
// The pipeline has four front stages (capture, products, sums, setup), one
// restoring-division stage per quotient bit plus an overflow stage, and the
// output register. Components are Q16.16.
// Reset clears only the valid bits. When the output is held, the whole
// pipeline holds, empty slots included, and the input is not taken.
module quaternion_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  a_r_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  a_i_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  a_j_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  a_k_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  b_r_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  b_i_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  b_j_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  b_k_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [qalu_pkg::PORT_W-1:0]  res_r_o,
  output logic signed [qalu_pkg::PORT_W-1:0]  res_i_o,
  output logic signed [qalu_pkg::PORT_W-1:0]  res_j_o,
  output logic signed [qalu_pkg::PORT_W-1:0]  res_k_o,
  output logic                                saturated_o,
  output logic                                divide_by_zero_o
);
  import qalu_pkg::*;

  logic               en;
  logic [3:0][CW-1:0] a, b;
  logic               front_valid, div_valid;
  front_t             front_data;
  quo_t               div_data;

  logic               out_valid_q;
  logic [3:0][CW-1:0] res_d, res_q;
  logic               sat_d, sat_q;
  logic               dz_d, dz_q;

  // advance everything unless a finished result is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign a = {a_k_i[CW-1:0], a_j_i[CW-1:0], a_i_i[CW-1:0], a_r_i[CW-1:0]};
  assign b = {b_k_i[CW-1:0], b_j_i[CW-1:0], b_i_i[CW-1:0], b_r_i[CW-1:0]};

  qalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && in_ready_o),
    .op_i    (op_e'(opcode_i)),
    .a_i     (a),
    .b_i     (b),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  qalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  always_comb begin
    logic signed [LW-1:0] qx;
    logic [CW:0]          r;
    logic [3:0][CW-1:0]   dv;
    logic                 dsat;
    dsat = 1'b0;
    for (int l = 0; l < 4; l++) begin
      qx    = $signed(LW'(div_data.quo[l]));
      r     = sat_f(div_data.ctl.neg[l] ? -qx : qx);
      dv[l] = r[CW-1:0];
      dsat  = dsat | r[CW];
    end
    dz_d = div_data.ctl.dz;
    if (div_data.ctl.op != OP_DIV) begin
      res_d = div_data.ctl.early;
      sat_d = div_data.ctl.early_sat;
    end else if (div_data.ctl.dz) begin
      res_d = '0;
      sat_d = 1'b0;
    end else begin
      res_d = dv;
      sat_d = dsat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_d;
      dz_q  <= dz_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign res_r_o          = PORT_W'($signed(res_q[0]));
  assign res_i_o          = PORT_W'($signed(res_q[1]));
  assign res_j_o          = PORT_W'($signed(res_q[2]));
  assign res_k_o          = PORT_W'($signed(res_q[3]));
  assign saturated_o      = sat_q;
  assign divide_by_zero_o = dz_q;

endmodule

// ----- hdl/qalu_checker.sv -----
module qalu_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic signed [qalu_pkg::PORT_W-1:0]  res_r_o,
  input  logic signed [qalu_pkg::PORT_W-1:0]  res_i_o,
  input  logic signed [qalu_pkg::PORT_W-1:0]  res_j_o,
  input  logic signed [qalu_pkg::PORT_W-1:0]  res_k_o,
  input  logic                                saturated_o,
  input  logic                                divide_by_zero_o
);
  import qalu_pkg::*;

  localparam logic signed [PORT_W-1:0] MAXV = PORT_W'({(CW-1){1'b1}});
  localparam logic signed [PORT_W-1:0] MINV = ~MAXV;

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_r_o) &&
      $stable(res_i_o) && $stable(res_j_o) && $stable(res_k_o) &&
      $stable(saturated_o) && $stable(divide_by_zero_o))
    else $error("held result changed");

  // no result while reset is applied
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result during reset");

  // a zero divisor gives a zero, unclamped result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> !saturated_o && res_r_o == '0 &&
      res_i_o == '0 && res_j_o == '0 && res_k_o == '0)
    else $error("divide by zero result not zero");

  // a clamp leaves at least one component at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> res_r_o == MAXV || res_r_o == MINV ||
      res_i_o == MAXV || res_i_o == MINV || res_j_o == MAXV ||
      res_j_o == MINV || res_k_o == MAXV || res_k_o == MINV)
    else $error("saturation flag without clamped component");

  // input is taken whenever the output side is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind quaternion_alu qalu_checker u_qalu_checker (.*);
